// File: sv/dctss_pkg.sv
`timescale 1ns / 1ps

package dctss_pkg;

    typedef enum logic
    {
        CMD_SAMPLE = 1'b0,
        CMD_TICK   = 1'b1
    } cmd_t;

    localparam logic [1:0] DIGIT_LETTER    = 2'd0;
    localparam logic [1:0] DIGIT_TENS      = 2'd1;
    localparam logic [1:0] DIGIT_HUNDREDS  = 2'd2;
    localparam logic [1:0] DIGIT_THOUSANDS = 2'd3;

    localparam logic [15:0] TOGGLE_PERIOD_RESET = 16'd500;

    localparam logic [7:0] SEG_LETTER_C = 8'h39;
    localparam logic [7:0] SEG_DOT      = 8'h80;

    localparam logic [7:0] SEG_DIGIT [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    // Shown digits of a saturated reading: thousands, hundreds, tens.
    localparam logic [11:0] BCD_SATURATED = 12'h999;

    typedef logic [11:0] bcd_table_t [256];

    // Samples 0..255 scaled to hundredths of a degree, clamped at 9999.
    function automatic bcd_table_t build_bcd_table();
        bcd_table_t t;
        int v;
        for (int i = 0; i < 256; i++)
        begin
            v = (50000 * i) / 1023;
            if (v > 9999)
            begin
                v = 9999;
            end
            t[i] = {4'((v / 1000) % 10), 4'((v / 100) % 10), 4'((v / 10) % 10)};
        end
        return t;
    endfunction

    localparam bcd_table_t BCD_TABLE = build_bcd_table();

endpackage

// File: sv/dual_channel_temp_seven_segment_scan_core.sv
`timescale 1ns / 1ps

// Two-channel thermometer scan core for a four-digit common-cathode display.
// Each item is either a converter sample (stored, no result) or a scan tick
// (one result: segment pattern, active-low digit enable, LED levels). One item
// is accepted per clock; an item passes an input register, one pass of table
// lookup and digit selection, and a result register, which takes a tick's result
// as the tick leaves the input register; a held result stalls ticks, not samples.
// Readings of 100.00 degrees or more show
// as 99.9 with the letter C. cfg_ready is always high; toggle_period (reset
// 500, 0 acts as 65536) sets the ticks between swaps of the shown channel.
module dual_channel_temp_seven_segment_scan_core
    import dctss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_stall,
    input  logic        cmd,
    input  logic        channel,
    input  logic [9:0]  sample_value,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  segments,
    output logic [3:0]  digit_enables_n,
    output logic        led_first,
    output logic        led_second,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic        s1_valid_reg;
    logic        s1_cmd_reg;
    logic        s1_channel_reg;
    logic [9:0]  s1_sample_reg;

    logic [15:0] toggle_period_reg;
    logic [9:0]  sample_zero_reg;
    logic [9:0]  sample_one_reg;
    logic [1:0]  scan_index_reg;
    logic [1:0]  scan_index_next;
    logic [15:0] tick_count_reg;
    logic [15:0] tick_count_next;
    logic        show_first_reg;
    logic        show_first_next;

    logic        result_valid_reg;
    logic [7:0]  segments_reg;
    logic [3:0]  digit_enables_n_reg;
    logic        led_first_reg;

    logic        out_free;
    logic        fire;
    logic        fire_tick;
    logic        fire_sample;
    logic [9:0]  shown_sample;
    logic [11:0] bcd;
    logic [7:0]  pattern;
    logic [15:0] tick_inc;

    assign cfg_ready = 1'b1;

    assign out_free    = !result_valid_reg || !result_stall;
    assign fire        = s1_valid_reg && ((s1_cmd_reg == CMD_SAMPLE) || out_free);
    assign fire_tick   = fire && (s1_cmd_reg == CMD_TICK);
    assign fire_sample = fire && (s1_cmd_reg == CMD_SAMPLE);
    assign item_stall  = s1_valid_reg && !fire;

    assign shown_sample = show_first_reg ? sample_zero_reg : sample_one_reg;
    assign bcd = (shown_sample[9:8] != 2'd0) ? BCD_SATURATED
                                             : BCD_TABLE[shown_sample[7:0]];

    always_comb
    begin
        case (scan_index_reg)
            DIGIT_LETTER:    pattern = SEG_LETTER_C;
            DIGIT_TENS:      pattern = SEG_DIGIT[bcd[3:0]];
            DIGIT_HUNDREDS:  pattern = SEG_DIGIT[bcd[7:4]] | SEG_DOT;
            DIGIT_THOUSANDS: pattern = SEG_DIGIT[bcd[11:8]];
            default:         pattern = SEG_LETTER_C;
        endcase
    end

    // Count wraps at 65536, so a period of zero matches only on the wrap.
    assign tick_inc = tick_count_reg + 16'd1;

    always_comb
    begin
        scan_index_next = scan_index_reg;
        tick_count_next = tick_count_reg;
        show_first_next = show_first_reg;
        if (fire_tick)
        begin
            scan_index_next = scan_index_reg + 2'd1;
            if (tick_inc == toggle_period_reg)
            begin
                tick_count_next = 16'd0;
                show_first_next = !show_first_reg;
            end
            else
            begin
                tick_count_next = tick_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            toggle_period_reg <= TOGGLE_PERIOD_RESET;
            sample_zero_reg   <= 10'd0;
            sample_one_reg    <= 10'd0;
            scan_index_reg    <= 2'd0;
            tick_count_reg    <= 16'd0;
            show_first_reg    <= 1'b1;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            if (!item_stall)
            begin
                s1_valid_reg <= item_valid;
            end
            if (cfg_valid && cfg_ready)
            begin
                toggle_period_reg <= cfg_data;
            end
            if (fire_sample)
            begin
                if (s1_channel_reg)
                begin
                    sample_one_reg <= s1_sample_reg;
                end
                else
                begin
                    sample_zero_reg <= s1_sample_reg;
                end
            end
            scan_index_reg <= scan_index_next;
            tick_count_reg <= tick_count_next;
            show_first_reg <= show_first_next;
            if (out_free)
            begin
                result_valid_reg <= fire_tick;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall)
        begin
            s1_cmd_reg     <= cmd;
            s1_channel_reg <= channel;
            s1_sample_reg  <= sample_value;
        end
        if (fire_tick)
        begin
            segments_reg        <= pattern;
            digit_enables_n_reg <= ~(4'b0001 << scan_index_reg);
            led_first_reg       <= show_first_reg;
        end
    end

    assign result_valid    = result_valid_reg;
    assign segments        = segments_reg;
    assign digit_enables_n = digit_enables_n_reg;
    assign led_first       = led_first_reg;
    assign led_second      = !led_first_reg;

    // A new result transaction only follows a tick leaving the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(s1_valid_reg && (s1_cmd_reg == CMD_TICK)))
        else $error("result without a tick");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($countones(~digit_enables_n) == 1))
        else $error("digit enable not one-cold");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire_tick |=> (scan_index_reg == 2'($past(scan_index_reg) + 2'd1)))
        else $error("scan index did not advance");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire_sample |=> ($stable(scan_index_reg) && $stable(tick_count_reg)
                         && $stable(show_first_reg)))
        else $error("sample disturbed scan state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |-> !fire_tick)
        else $error("tick fired into a held result");

endmodule

// File: bench/dual_channel_temp_seven_segment_scan_core_test.sv
`timescale 1ns / 1ps

module dual_channel_temp_seven_segment_scan_core_test
    import dctss_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIRECTED_ROWS  = 25;

    // segment glyphs for decimal digits 0..9, bit 0 = a
    localparam logic [7:0] GLYPH [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    typedef struct packed
    {
        logic [7:0] segments;
        logic [3:0] enables_n;
        logic       led_first;
        logic       led_second;
    } digit_drive_t;

    typedef struct
    {
        cmd_t         op;
        logic         chan;
        logic [9:0]   level;
        bit           fixed;
        digit_drive_t want;
    } scan_step_t;

    localparam digit_drive_t NONE = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic        cmd = 1'b0;
    logic        channel = 1'b0;
    logic [9:0]  sample_value = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [7:0]  segments;
    logic [3:0]  digit_enables_n;
    logic        led_first;
    logic        led_second;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    // predictor state
    logic [9:0]  reading [2] = '{10'd0, 10'd0};
    logic [1:0]  digit_pos = DIGIT_LETTER;
    logic [15:0] tick_count = '0;
    logic        showing_first = 1'b1;
    logic [15:0] swap_period = TOGGLE_PERIOD_RESET;

    digit_drive_t digit_drives [$];

    int  bad_digits = 0;
    int  ticks_sent = 0;
    int  samples_sent = 0;
    int  digits_checked = 0;
    int  period_writes = 0;
    int  swaps = 0;
    int  quiet_cycles = 0;
    int  stall_left = 0;
    bit  idle_on = 1'b0;

    // after reset: all samples zero, channel 0 shown, scan starts at the letter
    scan_step_t directed [DIRECTED_ROWS] = '{
        '{CMD_TICK,   1'b0, 10'd0,    1'b1, '{8'h39, 4'b1110, 1'b1, 1'b0}},
        '{CMD_SAMPLE, 1'b0, 10'd1023, 1'b0, NONE},
        '{CMD_TICK,   1'b1, 10'd1023, 1'b1, '{8'h6F, 4'b1101, 1'b1, 1'b0}},
        '{CMD_TICK,   1'b0, 10'd0,    1'b1, '{8'hEF, 4'b1011, 1'b1, 1'b0}},
        '{CMD_TICK,   1'b1, 10'd512,  1'b1, '{8'h6F, 4'b0111, 1'b1, 1'b0}},
        '{CMD_SAMPLE, 1'b0, 10'd0,    1'b0, NONE},
        '{CMD_TICK,   1'b0, 10'd0,    1'b1, '{8'h39, 4'b1110, 1'b1, 1'b0}},
        '{CMD_TICK,   1'b0, 10'd0,    1'b1, '{8'h3F, 4'b1101, 1'b1, 1'b0}},
        '{CMD_TICK,   1'b0, 10'd0,    1'b1, '{8'hBF, 4'b1011, 1'b1, 1'b0}},
        '{CMD_TICK,   1'b0, 10'd0,    1'b1, '{8'h3F, 4'b0111, 1'b1, 1'b0}},
        '{CMD_SAMPLE, 1'b1, 10'd1023, 1'b0, NONE},
        '{CMD_SAMPLE, 1'b0, 10'd204,  1'b0, NONE},
        '{CMD_TICK,   1'b0, 10'd0,    1'b0, NONE},
        '{CMD_TICK,   1'b0, 10'd0,    1'b0, NONE},
        '{CMD_TICK,   1'b0, 10'd0,    1'b0, NONE},
        '{CMD_TICK,   1'b0, 10'd0,    1'b0, NONE},
        '{CMD_SAMPLE, 1'b0, 10'd205,  1'b0, NONE},
        '{CMD_TICK,   1'b0, 10'd0,    1'b0, NONE},
        '{CMD_TICK,   1'b0, 10'd0,    1'b0, NONE},
        '{CMD_TICK,   1'b0, 10'd0,    1'b0, NONE},
        '{CMD_TICK,   1'b0, 10'd0,    1'b0, NONE},
        '{CMD_SAMPLE, 1'b1, 10'h155,  1'b0, NONE},
        '{CMD_SAMPLE, 1'b0, 10'h2AA,  1'b0, NONE},
        '{CMD_TICK,   1'b0, 10'd0,    1'b0, NONE},
        '{CMD_TICK,   1'b0, 10'd0,    1'b0, NONE}
    };

    dual_channel_temp_seven_segment_scan_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .cmd             (cmd),
        .channel         (channel),
        .sample_value    (sample_value),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .segments        (segments),
        .digit_enables_n (digit_enables_n),
        .led_first       (led_first),
        .led_second      (led_second),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // One display tick: drive the current digit, then advance scan and swap timer.
    function automatic digit_drive_t scan_tick();
        digit_drive_t d;
        int unsigned  hundredths;
        hundredths = (50000 * reading[showing_first ? 0 : 1]) / 1023;
        if (hundredths > 9999)
        begin
            hundredths = 9999;
        end
        case (digit_pos)
            DIGIT_LETTER:    d.segments = SEG_LETTER_C;
            DIGIT_TENS:      d.segments = GLYPH[(hundredths / 10) % 10];
            DIGIT_HUNDREDS:  d.segments = GLYPH[(hundredths / 100) % 10] | SEG_DOT;
            default:         d.segments = GLYPH[(hundredths / 1000) % 10];
        endcase
        d.enables_n  = ~(4'b0001 << digit_pos);
        d.led_first  = showing_first;
        d.led_second = !showing_first;
        digit_pos  = digit_pos + 2'd1;
        tick_count = tick_count + 16'd1;
        if (tick_count == swap_period)
        begin
            tick_count    = '0;
            showing_first = !showing_first;
            swaps++;
        end
        return d;
    endfunction

    function automatic scan_step_t random_step(int tick_pct);
        scan_step_t s;
        s.fixed = 1'b0;
        s.want  = NONE;
        s.chan  = 1'($urandom_range(0, 1));
        s.op    = ($urandom_range(0, 99) < tick_pct) ? CMD_TICK : CMD_SAMPLE;
        case ($urandom_range(0, 3))
            0:       s.level = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
            1:       s.level = 10'($urandom_range(198, 212));   // around saturation
            default: s.level = 10'($urandom_range(0, 1023));
        endcase
        return s;
    endfunction

    task automatic send(input scan_step_t s);
        digit_drive_t d;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        item_valid   <= 1'b1;
        cmd          <= s.op;
        channel      <= s.chan;
        sample_value <= s.level;
        do @(posedge clk); while (item_stall);
        if (s.op == CMD_TICK)
        begin
            d = scan_tick();
            if (s.fixed)
            begin
                d = s.want;
            end
            digit_drives.push_back(d);
            ticks_sent++;
        end
        else
        begin
            reading[s.chan] = s.level;
            samples_sent++;
        end
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        do @(posedge clk); while (digit_drives.size() != 0);
    endtask

    task automatic write_period(input logic [15:0] p);
        drain_results();
        // a sample may still be in flight with nothing expected
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= p;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        swap_period = p;
        period_writes++;
    endtask

    task automatic random_phase(input int count);
        for (int k = 0; k < count; k++)
        begin
            send(random_step(65));
        end
    endtask

    task automatic long_tick_run(input int ticks);
        scan_step_t s;
        int         done;
        done = 0;
        while (done < ticks)
        begin
            s = random_step(98);
            send(s);
            if (s.op == CMD_TICK)
            begin
                done++;
            end
        end
    endtask

    task automatic report_bad(input bit orphan, input digit_drive_t want,
                              input digit_drive_t got);
        bad_digits++;
        if (bad_digits <= 10)
        begin
            if (orphan)
            begin
                $display("%0t unexpected transaction: seg %h en %b leds %b%b",
                         $realtime, got.segments, got.enables_n, got.led_first,
                         got.led_second);
            end
            else
            begin
                $display("%0t expected seg %h en %b leds %b%b, got seg %h en %b leds %b%b",
                         $realtime, want.segments, want.enables_n, want.led_first,
                         want.led_second, got.segments, got.enables_n, got.led_first,
                         got.led_second);
            end
        end
    endtask

    // result side: check accepted transactions, then pick next stall level
    always @(posedge clk)
    begin
        digit_drive_t got;
        digit_drive_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            got = '{segments, digit_enables_n, led_first, led_second};
            if (digit_drives.size() == 0)
            begin
                report_bad(1'b1, NONE, got);
            end
            else
            begin
                want = digit_drives.pop_front();
                digits_checked++;
                if (got.segments !== want.segments || got.enables_n !== want.enables_n
                    || got.led_first !== want.led_first
                    || got.led_second !== want.led_second)
                begin
                    report_bad(1'b0, want, got);
                end
            end
        end
        if (stall_left != 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 4);
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((item_valid && !item_stall) || (result_valid && !result_stall)
                 || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("dual_channel_temp_seven_segment_scan_core: mismatch");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on = 1'b1;

        foreach (directed[i])
        begin
            send(directed[i]);
        end

        write_period(16'd1);
        random_phase(300);
        write_period(16'd3);
        random_phase(150);
        drain_results();
        random_phase(150);
        write_period(16'hFFFF);
        random_phase(200);
        write_period(16'd7);
        random_phase(200);

        // drop the period beneath the running count: no swap, the counter runs on
        idle_on = 1'b0;
        write_period(16'd40);
        long_tick_run(30);
        write_period(16'd10);
        long_tick_run(40);
        // zero period: no swap before the 16-bit wrap
        write_period(16'd0);
        long_tick_run(60);

        idle_on = 1'b1;
        repeat (3)
        begin
            write_period(16'($urandom_range(2, 16)));
            random_phase(100);
        end
        idle_on = 1'b0;
        write_period(16'd2);
        random_phase(200);

        drain_results();
        repeat (8) @(posedge clk);

        $display("%0d ticks, %0d samples, %0d digits checked, %0d period writes",
                 ticks_sent, samples_sent, digits_checked, period_writes);
        $display("%0d channel swaps, %0d bad digits", swaps, bad_digits);
        if (bad_digits == 0)
        begin
            $display("dual_channel_temp_seven_segment_scan_core: match");
        end
        else
        begin
            $display("dual_channel_temp_seven_segment_scan_core: mismatch");
        end
        $finish;
    end

endmodule
